// File: rtl/quaternion_to_euler_unit_assert.svh
// Assertion macros for the quaternion to Euler unit.
`ifndef QUATERNION_TO_EULER_UNIT_ASSERT_SVH
`define QUATERNION_TO_EULER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define Q2E_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define Q2E_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define Q2E_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define Q2E_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// File: rtl/q2e_pkg.sv
package q2e_pkg;
   localparam int SUM_W    = 36;  // sums of products and the pitch sine
   localparam int CW       = 38;  // CORDIC vector width
   localparam int ANG_W    = 34;  // internal angle, 2^31 = pi
   localparam int SQ_STEPS = 29;  // result bits of the square root
   localparam int SQ_W     = 58;

   localparam logic signed [SUM_W-1:0] ONE_Q28     = SUM_W'(268435456);
   localparam logic signed [SUM_W-1:0] NEG_ONE_Q28 = -SUM_W'(268435456);
   localparam logic signed [ANG_W-1:0] HALF_PI     = ANG_W'(1073741824);
   localparam logic signed [18:0]      PITCH_MAX   = 19'sd16384;
   localparam logic signed [18:0]      PITCH_MIN   = -19'sd16384;

   typedef struct packed {
      logic signed [SUM_W-1:0] sr;
      logic signed [SUM_W-1:0] cr;
      logic signed [SUM_W-1:0] sy;
      logic signed [SUM_W-1:0] cy;
      logic signed [28:0]      sp;
      logic                    sat;
      logic                    sat_neg;
   } side_type;

   typedef struct packed {
      logic sat;
      logic sat_neg;
   } clamp_type;

   // atan(2^-i), 2^31 = pi
   function automatic logic signed [ANG_W-1:0] atan_entry(input int unsigned i);
      logic signed [ANG_W-1:0] v;
      case (i)
         0:  v = ANG_W'(536870912);
         1:  v = ANG_W'(316933406);
         2:  v = ANG_W'(167458907);
         3:  v = ANG_W'(85004756);
         4:  v = ANG_W'(42667331);
         5:  v = ANG_W'(21354465);
         6:  v = ANG_W'(10679838);
         7:  v = ANG_W'(5340245);
         8:  v = ANG_W'(2670163);
         9:  v = ANG_W'(1335087);
         10: v = ANG_W'(667544);
         11: v = ANG_W'(333772);
         12: v = ANG_W'(166886);
         13: v = ANG_W'(83443);
         14: v = ANG_W'(41722);
         15: v = ANG_W'(20861);
         16: v = ANG_W'(10430);
         17: v = ANG_W'(5215);
         18: v = ANG_W'(2608);
         19: v = ANG_W'(1304);
         20: v = ANG_W'(652);
         21: v = ANG_W'(326);
         22: v = ANG_W'(163);
         23: v = ANG_W'(81);
         24: v = ANG_W'(41);
         25: v = ANG_W'(20);
         26: v = ANG_W'(10);
         27: v = ANG_W'(5);
         28: v = ANG_W'(3);
         29: v = ANG_W'(1);
         30: v = ANG_W'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

   // floor((a + 2^15) / 2^16)
   function automatic logic signed [18:0] bau_round(input logic signed [ANG_W-1:0] a);
      logic signed [ANG_W:0] t;
      t = (ANG_W+1)'(a) + (ANG_W+1)'(32768);
      return 19'(t >>> 16);
   endfunction
endpackage

// File: rtl/q2e_isqrt.sv
module q2e_isqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [56:0]                in_value,
   output logic                       out_valid,
   output logic [q2e_pkg::SQ_STEPS-1:0] out_root
);
   import q2e_pkg::*;

   logic [56:0]     n_ff [1:SQ_STEPS];
   logic [SQ_W-1:0] r_ff [1:SQ_STEPS];
   logic            v_ff [1:SQ_STEPS];

   // one result bit per stage
   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
      localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << (56 - 2*k);
      logic [56:0]     n_src, n_in;
      logic [SQ_W-1:0] r_src, r_in, trial;
      logic            v_src;
      if (k == 0) begin : g_first
         assign n_src = in_value;
         assign r_src = '0;
         assign v_src = in_valid;
      end else begin : g_rest
         assign n_src = n_ff[k];
         assign r_src = r_ff[k];
         assign v_src = v_ff[k];
      end
      always_comb begin
         trial = r_src + BITV;
         if ({1'b0, n_src} >= trial) begin
            n_in = n_src - trial[56:0];
            r_in = (r_src >> 1) + BITV;
         end else begin
            n_in = n_src;
            r_in = r_src >> 1;
         end
      end
      always_ff @(posedge clock) begin
         n_ff[k+1] <= n_in;
         r_ff[k+1] <= r_in;
         if (reset) v_ff[k+1] <= 1'b0;
         else       v_ff[k+1] <= v_src;
      end
   end

   assign out_valid = v_ff[SQ_STEPS];
   assign out_root  = r_ff[SQ_STEPS][SQ_STEPS-1:0];
endmodule

// File: rtl/q2e_cordic.sv
module q2e_cordic #(
   parameter int ITER = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic signed [q2e_pkg::CW-1:0]    in_y,
   input  logic signed [q2e_pkg::CW-1:0]    in_x,
   output logic                             out_valid,
   output logic signed [q2e_pkg::ANG_W-1:0] out_angle
);
   import q2e_pkg::*;

   logic signed [CW-1:0]    x_ff [0:ITER];
   logic signed [CW-1:0]    y_ff [0:ITER];
   logic signed [ANG_W-1:0] a_ff [0:ITER];
   logic                    z_ff [0:ITER];
   logic                    v_ff [0:ITER];

   logic signed [CW-1:0]    x_in, y_in;
   logic signed [ANG_W-1:0] a_in;

   // quadrant pre-rotation into the right half plane
   always_comb begin
      x_in = in_x;
      y_in = in_y;
      a_in = '0;
      if (in_x < 0) begin
         if (in_y >= 0) begin
            x_in = in_y;
            y_in = -in_x;
            a_in = HALF_PI;
         end else begin
            x_in = -in_y;
            y_in = in_x;
            a_in = -HALF_PI;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0] <= x_in;
      y_ff[0] <= y_in;
      a_ff[0] <= a_in;
      z_ff[0] <= (in_x == 0) && (in_y == 0);
      if (reset) v_ff[0] <= 1'b0;
      else       v_ff[0] <= in_valid;
   end

   for (genvar i = 0; i < ITER; i++) begin : g_iter
      logic signed [CW-1:0] dx, dy;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (y_ff[i] >= 0) begin
            x_ff[i+1] <= x_ff[i] + dx;
            y_ff[i+1] <= y_ff[i] - dy;
            a_ff[i+1] <= a_ff[i] + atan_entry(i);
         end else begin
            x_ff[i+1] <= x_ff[i] - dx;
            y_ff[i+1] <= y_ff[i] + dy;
            a_ff[i+1] <= a_ff[i] - atan_entry(i);
         end
         z_ff[i+1] <= z_ff[i];
         if (reset) v_ff[i+1] <= 1'b0;
         else       v_ff[i+1] <= v_ff[i];
      end
   end

   assign out_valid = v_ff[ITER];
   assign out_angle = z_ff[ITER] ? '0 : a_ff[ITER];
endmodule

// File: rtl/quaternion_to_euler_unit.sv
// Quaternion to ZYX Euler angles. Give a Q1.14 quaternion with start; busy is
// always low, so an item enters every clock. Its roll, pitch and yaw are held
// on the result ports for one cycle, marked by rsp_valid. The receiver cannot
// stall, so results must be taken as they appear. The pipeline is the product,
// quadratic form and sine square registers (3), the 29-stage square root that
// forms the pitch cosine, one pre-rotation stage, one stage per CORDIC
// iteration and the output register. Angles are binary angle units
// (32768 = pi). Pitch is clamped to +-16384 with rsp_pitch_saturated set when
// the sine term reaches magnitude one.
`include "quaternion_to_euler_unit_assert.svh"
module quaternion_to_euler_unit #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_roll_angle,
   output logic signed [15:0] rsp_pitch_angle,
   output logic signed [15:0] rsp_yaw_angle,
   output logic               rsp_pitch_saturated
);
   import q2e_pkg::*;

   localparam int LATENCY = SQ_STEPS + CORDIC_ITERATIONS + 5;

   // the pipeline never holds off an item
   assign busy = 1'b0;
   logic accept;
   assign accept = start && !busy;

   // stage 1: products
   logic signed [31:0] wx_ff, yz_ff, xx_ff, yy_ff, wy_ff, zx_ff, wz_ff, xy_ff, zz_ff;
   logic               v1_ff;
   always_ff @(posedge clock) begin
      wx_ff <= req_quat_w * req_quat_x;
      yz_ff <= req_quat_y * req_quat_z;
      xx_ff <= req_quat_x * req_quat_x;
      yy_ff <= req_quat_y * req_quat_y;
      wy_ff <= req_quat_w * req_quat_y;
      zx_ff <= req_quat_z * req_quat_x;
      wz_ff <= req_quat_w * req_quat_z;
      xy_ff <= req_quat_x * req_quat_y;
      zz_ff <= req_quat_z * req_quat_z;
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= accept;
   end

   // stage 2: the five quadratic forms in Q.28, plus the pitch clamp test
   logic signed [SUM_W-1:0] sr_in, cr_in, sp_in, sy_in, cy_in;
   logic signed [SUM_W-1:0] sr_ff, cr_ff, sp_ff, sy_ff, cy_ff;
   logic                    sat_ff, sat_neg_ff, v2_ff;
   always_comb begin
      sr_in = (SUM_W'(wx_ff) + SUM_W'(yz_ff)) <<< 1;
      cr_in = ONE_Q28 - ((SUM_W'(xx_ff) + SUM_W'(yy_ff)) <<< 1);
      sp_in = (SUM_W'(wy_ff) - SUM_W'(zx_ff)) <<< 1;
      sy_in = (SUM_W'(wz_ff) + SUM_W'(xy_ff)) <<< 1;
      cy_in = ONE_Q28 - ((SUM_W'(yy_ff) + SUM_W'(zz_ff)) <<< 1);
   end
   always_ff @(posedge clock) begin
      sr_ff      <= sr_in;
      cr_ff      <= cr_in;
      sp_ff      <= sp_in;
      sy_ff      <= sy_in;
      cy_ff      <= cy_in;
      sat_ff     <= (sp_in >= ONE_Q28) || (sp_in <= NEG_ONE_Q28);
      sat_neg_ff <= sp_in <= NEG_ONE_Q28;
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
   end

   // stage 3: square of the sine; only its low bits matter when unclamped
   logic signed [28:0] sp_narrow;
   logic signed [57:0] s2_in, s2_ff;
   side_type           side3_ff;
   logic               v3_ff;
   assign sp_narrow = sp_ff[28:0];
   assign s2_in     = sp_narrow * sp_narrow;
   always_ff @(posedge clock) begin
      s2_ff <= s2_in;
      side3_ff <= '{sr: sr_ff, cr: cr_ff, sy: sy_ff, cy: cy_ff, sp: sp_narrow,
                    sat: sat_ff, sat_neg: sat_neg_ff};
      if (reset) v3_ff <= 1'b0;
      else       v3_ff <= v2_ff;
   end

   // pitch cosine: isqrt(1 - s^2) in Q.28
   logic [56:0]          sq_arg;
   logic                 sq_valid;
   logic [SQ_STEPS-1:0]  cosp;
   assign sq_arg = (57'(1) << 56) - s2_ff[56:0];

   q2e_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .in_value  (sq_arg),
      .out_valid (sq_valid),
      .out_root  (cosp)
   );

   // hold the other operands alongside the square root
   side_type side_ff [0:SQ_STEPS-1];
   always_ff @(posedge clock) begin
      side_ff[0] <= side3_ff;
      for (int k = 1; k < SQ_STEPS; k++) side_ff[k] <= side_ff[k-1];
   end
   side_type side_q;
   assign side_q = side_ff[SQ_STEPS-1];

   // three angle pipelines in lockstep
   logic                    roll_v, pitch_v, yaw_v;
   logic signed [ANG_W-1:0] roll_a, pitch_a, yaw_a;
   logic signed [CW-1:0]    cos_ext;
   assign cos_ext = signed'(CW'(cosp));

   q2e_cordic #(.ITER(CORDIC_ITERATIONS)) u_roll (
      .clock (clock), .reset (reset), .in_valid (sq_valid),
      .in_y (CW'(side_q.sr)), .in_x (CW'(side_q.cr)),
      .out_valid (roll_v), .out_angle (roll_a)
   );
   q2e_cordic #(.ITER(CORDIC_ITERATIONS)) u_pitch (
      .clock (clock), .reset (reset), .in_valid (sq_valid),
      .in_y (CW'(side_q.sp)), .in_x (cos_ext),
      .out_valid (pitch_v), .out_angle (pitch_a)
   );
   q2e_cordic #(.ITER(CORDIC_ITERATIONS)) u_yaw (
      .clock (clock), .reset (reset), .in_valid (sq_valid),
      .in_y (CW'(side_q.sy)), .in_x (CW'(side_q.cy)),
      .out_valid (yaw_v), .out_angle (yaw_a)
   );

   // carry the clamp flags through the CORDIC stages
   clamp_type clamp_ff [0:CORDIC_ITERATIONS];
   always_ff @(posedge clock) begin
      clamp_ff[0] <= '{sat: side_q.sat, sat_neg: side_q.sat_neg};
      for (int k = 1; k <= CORDIC_ITERATIONS; k++) clamp_ff[k] <= clamp_ff[k-1];
   end
   clamp_type clamp_q;
   assign clamp_q = clamp_ff[CORDIC_ITERATIONS];

   // output stage: round to binary angle units, clamp pitch
   logic signed [18:0] roll_r, pitch_r, yaw_r;
   logic signed [15:0] pitch_in;
   assign roll_r  = bau_round(roll_a);
   assign pitch_r = bau_round(pitch_a);
   assign yaw_r   = bau_round(yaw_a);
   always_comb begin
      if (clamp_q.sat)             pitch_in = clamp_q.sat_neg ? -16'sd16384 : 16'sd16384;
      else if (pitch_r > PITCH_MAX) pitch_in = 16'sd16384;
      else if (pitch_r < PITCH_MIN) pitch_in = -16'sd16384;
      else                          pitch_in = pitch_r[15:0];
   end

   logic signed [15:0] roll_ff, pitch_ff, yaw_ff;
   logic               sat_out_ff, out_v_ff;
   always_ff @(posedge clock) begin
      roll_ff    <= roll_r[15:0];  // +pi wraps to -pi
      pitch_ff   <= pitch_in;
      yaw_ff     <= yaw_r[15:0];
      sat_out_ff <= clamp_q.sat;
      if (reset) out_v_ff <= 1'b0;
      else       out_v_ff <= roll_v && pitch_v && yaw_v;
   end

   assign rsp_valid           = out_v_ff;
   assign rsp_roll_angle      = roll_ff;
   assign rsp_pitch_angle     = pitch_ff;
   assign rsp_yaw_angle       = yaw_ff;
   assign rsp_pitch_saturated = sat_out_ff;

   logic pitch_ok, pitch_at_clamp, lane_any, lane_all;
   assign pitch_ok       = (rsp_pitch_angle <= 16'sd16384) && (rsp_pitch_angle >= -16'sd16384);
   assign pitch_at_clamp = (rsp_pitch_angle == 16'sd16384) || (rsp_pitch_angle == -16'sd16384);
   assign lane_any       = roll_v || pitch_v || yaw_v;
   assign lane_all       = roll_v && pitch_v && yaw_v;

   `Q2E_ASSERT_SAME(a_pitch_range, clock, reset, rsp_valid, pitch_ok, "pitch out of range")
   `Q2E_ASSERT_SAME(a_sat_value, clock, reset, rsp_valid && rsp_pitch_saturated, pitch_at_clamp, "clamp off")
   `Q2E_ASSERT_SAME(a_lanes_aligned, clock, reset, lane_any, lane_all, "lanes out of step")
   `Q2E_ASSERT_SAME(a_latency, clock, reset, rsp_valid, $past(accept, LATENCY), "orphan result")
endmodule

// File: tb/tb_quaternion_to_euler_unit.sv
`timescale 1ns / 1ps
module tb_quaternion_to_euler_unit;
   import q2e_pkg::*;

   localparam int ITER     = 16;
   localparam int LATENCY  = ITER + 34;
   localparam int N_RANDOM = 1850;

   typedef struct {
      logic signed [15:0] w, x, y, z;
   } quat_type;

   typedef struct {
      logic signed [15:0] roll, pitch, yaw;
      logic               sat;
   } euler_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [15:0] req_quat_w = '0;
   logic signed [15:0] req_quat_x = '0;
   logic signed [15:0] req_quat_y = '0;
   logic signed [15:0] req_quat_z = '0;
   logic               rsp_valid;
   logic signed [15:0] rsp_roll_angle, rsp_pitch_angle, rsp_yaw_angle;
   logic               rsp_pitch_saturated;

   quat_type  pending_quats[$];
   euler_type expected_angles[$];
   int     error_count = 0;
   int     items_sent = 0;
   int     angles_seen = 0;
   int     sat_seen = 0;
   bit     stimulus_done = 1'b0;

   quaternion_to_euler_unit #(.CORDIC_ITERATIONS(ITER)) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_quat_w(req_quat_w), .req_quat_x(req_quat_x),
      .req_quat_y(req_quat_y), .req_quat_z(req_quat_z),
      .rsp_valid(rsp_valid), .rsp_roll_angle(rsp_roll_angle),
      .rsp_pitch_angle(rsp_pitch_angle), .rsp_yaw_angle(rsp_yaw_angle),
      .rsp_pitch_saturated(rsp_pitch_saturated)
   );

   always #5 clock = ~clock;

   // Arithmetic shift right, floor semantics on 64-bit signed values.
   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint atan_table(int i);
      longint tab[32] = '{536870912, 316933406, 167458907, 85004756, 42667331,
         21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
         83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41,
         20, 10, 5, 3, 1, 1, 0};
      return tab[i];
   endfunction

   // Vectoring CORDIC atan2, 2^31 = pi, with quadrant pre-rotation.
   function automatic longint cordic_angle(longint sy, longint sx);
      longint a, t, dx, dy;
      a = 0;
      if (sx == 0 && sy == 0) return 0;
      if (sx < 0) begin
         if (sy >= 0) begin
            t = sx; sx = sy; sy = -t; a = 64'sd1073741824;
         end else begin
            t = sx; sx = -sy; sy = t; a = -64'sd1073741824;
         end
      end
      for (int i = 0; i < ITER; i++) begin
         dx = floor_shift(sy, i);
         dy = floor_shift(sx, i);
         if (sy >= 0) begin
            sx += dx; sy -= dy; a += longint'(atan_table(i));
         end else begin
            sx -= dx; sy += dy; a -= longint'(atan_table(i));
         end
      end
      return a;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b; res = (res >> 1) + b;
         end else res >>= 1;
         b >>= 2;
      end
      return res;
   endfunction

   function automatic logic signed [15:0] to_bau(longint a);
      return 16'(floor_shift(a + 32768, 16));
   endfunction

   function automatic euler_type predict_euler(quat_type q);
      longint w, x, y, z, sr, cr, sp, sy, cy, c, p;
      euler_type e;
      w = q.w; x = q.x; y = q.y; z = q.z;
      sr = 2 * (w * x + y * z);
      cr = 64'sd268435456 - 2 * (x * x + y * y);
      sp = 2 * (w * y - z * x);
      sy = 2 * (w * z + x * y);
      cy = 64'sd268435456 - 2 * (y * y + z * z);
      e.sat = 1'b0;
      if (sp >= 64'sd268435456) begin
         e.pitch = 16'sd16384; e.sat = 1'b1;
      end else if (sp <= -64'sd268435456) begin
         e.pitch = -16'sd16384; e.sat = 1'b1;
      end else begin
         c = longint'(int_sqrt((64'd1 << 56) - longint'(sp * sp)));
         p = floor_shift(cordic_angle(sp, c) + 32768, 16);
         if (p > 16384) p = 16384;
         if (p < -16384) p = -16384;
         e.pitch = 16'(p);
      end
      e.roll = to_bau(cordic_angle(sr, cr));
      e.yaw  = to_bau(cordic_angle(sy, cy));
      return e;
   endfunction

   function automatic int idle_gap();
      if ($urandom_range(0, 99) < 40) return 0;
      if ($urandom_range(0, 99) < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   // Random unit-ish quaternion in Q1.14: scale a random direction to |q| ~ 1.
   function automatic quat_type random_unit();
      quat_type q;
      real a, b, c, d, n;
      a = $itor($signed($urandom_range(0, 65535)) - 32768);
      b = $itor($signed($urandom_range(0, 65535)) - 32768);
      c = $itor($signed($urandom_range(0, 65535)) - 32768);
      d = $itor($signed($urandom_range(0, 65535)) - 32768);
      n = $sqrt(a * a + b * b + c * c + d * d);
      if (n < 1.0) n = 1.0;
      q.w = 16'($rtoi(a * 16384.0 / n));
      q.x = 16'($rtoi(b * 16384.0 / n));
      q.y = 16'($rtoi(c * 16384.0 / n));
      q.z = 16'($rtoi(d * 16384.0 / n));
      return q;
   endfunction

   function automatic quat_type make_quat(int w, int x, int y, int z);
      quat_type q;
      q.w = 16'(w); q.x = 16'(x); q.y = 16'(y); q.z = 16'(z);
      return q;
   endfunction

   // Fill the item queue: directed corners first, then random.
   initial begin
      quat_type q;
      int    k;
      pending_quats.push_back(make_quat(16384, 0, 0, 0));      // identity
      pending_quats.push_back(make_quat(0, 0, 0, 0));          // zero quaternion
      pending_quats.push_back(make_quat(0, 16384, 0, 0));      // roll of pi, wraps
      pending_quats.push_back(make_quat(0, 0, 0, 16384));      // yaw of pi
      pending_quats.push_back(make_quat(0, -16384, 0, 0));
      pending_quats.push_back(make_quat(11585, 0, 11585, 0));  // pitch just inside +1
      pending_quats.push_back(make_quat(11585, 0, -11585, 0)); // pitch just inside -1
      pending_quats.push_back(make_quat(11586, 0, 11586, 0));  // just over +1
      pending_quats.push_back(make_quat(11584, 0, 11585, 0));  // just under +1
      pending_quats.push_back(make_quat(11585, 11585, 0, 0));
      pending_quats.push_back(make_quat(-16384, -16384, -16384, -16384));
      pending_quats.push_back(make_quat(16384, 16384, 16384, 16384));
      pending_quats.push_back(make_quat(-32768, -32768, -32768, -32768));
      pending_quats.push_back(make_quat(32767, 32767, 32767, 32767));
      pending_quats.push_back(make_quat(32767, -32768, 32767, -32768));
      pending_quats.push_back(make_quat(-32768, 32767, -32768, 32767));
      pending_quats.push_back(make_quat(8192, 8192, 8192, 8192));
      pending_quats.push_back(make_quat(8192, -8192, 8192, 8192));
      pending_quats.push_back(make_quat(0, 0, 16384, 0));
      pending_quats.push_back(make_quat(-1, -1, -1, -1));
      for (int i = 0; i < N_RANDOM; i++) begin
         k = $urandom_range(0, 99);
         if (k < 70) q = random_unit();
         else if (k < 80) begin
            // Near gimbal lock: drive 2(wy - zx) around plus or minus one.
            q = random_unit();
            q.w = 16'sd11585 + 16'($urandom_range(0, 8)) - 16'sd4;
            q.y = ($urandom_range(0, 1) ? 16'sd11585 : -16'sd11585)
                  + 16'($urandom_range(0, 8)) - 16'sd4;
            q.x = 16'($urandom_range(0, 64)) - 16'sd32;
            q.z = 16'($urandom_range(0, 64)) - 16'sd32;
         end else begin
            // Any bit pattern.
            q.w = 16'($urandom); q.x = 16'($urandom);
            q.y = 16'($urandom); q.z = 16'($urandom);
         end
         pending_quats.push_back(q);
      end
   end

   // Driver: present items at the falling edge with random gaps.
   initial begin
      quat_type q;
      int    gap;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (pending_quats.size() > 0) begin
         gap = idle_gap();
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         q = pending_quats.pop_front();
         start      <= 1'b1;
         req_quat_w <= q.w;
         req_quat_x <= q.x;
         req_quat_y <= q.y;
         req_quat_z <= q.z;
         // Hold the item until a rising edge takes it.
         do @(posedge clock); while (busy);
         expected_angles.push_back(predict_euler(q));
         items_sent++;
         @(negedge clock);
      end
      start <= 1'b0;
      stimulus_done = 1'b1;
   end

   // Monitor: compare each strobed result with the oldest expectation.
   always @(posedge clock) begin
      euler_type e;
      if (!reset && rsp_valid) begin
         if (expected_angles.size() == 0) begin
            $error("result with no item outstanding");
            error_count++;
         end else begin
            e = expected_angles.pop_front();
            angles_seen++;
            if (e.sat) sat_seen++;
            if (rsp_roll_angle !== e.roll) begin
               $error("roll_angle expected %0d actual %0d", e.roll, rsp_roll_angle);
               error_count++;
            end
            if (rsp_pitch_angle !== e.pitch) begin
               $error("pitch_angle expected %0d actual %0d", e.pitch, rsp_pitch_angle);
               error_count++;
            end
            if (rsp_yaw_angle !== e.yaw) begin
               $error("yaw_angle expected %0d actual %0d", e.yaw, rsp_yaw_angle);
               error_count++;
            end
            if (rsp_pitch_saturated !== e.sat) begin
               $error("pitch_saturated expected %0d actual %0d", e.sat,
                      rsp_pitch_saturated);
               error_count++;
            end
         end
      end
   end

   // End of run: drain, wait out the pipeline, report.
   initial begin
      wait (stimulus_done);
      while (expected_angles.size() > 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      $display("Sent %0d quaternions, checked %0d angle triples (%0d pitch clamps).",
               items_sent, angles_seen, sat_seen);
      if (error_count == 0 && expected_angles.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #5ms;
      $display("Timeout with %0d results outstanding.", expected_angles.size());
      $display("DONE: errors detected");
      $finish;
   end
endmodule

// File: quaternion_to_euler_unit.f
+incdir+rtl
rtl/q2e_pkg.sv
rtl/q2e_isqrt.sv
rtl/q2e_cordic.sv
rtl/quaternion_to_euler_unit.sv
tb/tb_quaternion_to_euler_unit.sv
